// ----- design/mpw_pkg.sv -----
// ----------------------------------------------------------------------------
// mpw_pkg
// Shared types and constants of the max pool window engine.
// ----------------------------------------------------------------------------
package mpw_pkg;

   localparam logic [31:0] NEG_FLT_MAX = 32'hFF7F_FFFF;

   localparam logic OP_STORE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam int CSR_IN_HEIGHT = 0;
   localparam int CSR_IN_WIDTH  = 1;
   localparam int CSR_KERNEL_H  = 2;
   localparam int CSR_KERNEL_W  = 3;
   localparam int CSR_STRIDE_H  = 4;
   localparam int CSR_STRIDE_W  = 5;
   localparam int CSR_PAD_H     = 6;
   localparam int CSR_PAD_W     = 7;

   typedef struct packed {
      logic [6:0] in_height;
      logic [6:0] in_width;
      logic [3:0] kernel_h;
      logic [3:0] kernel_w;
      logic [3:0] stride_h;
      logic [3:0] stride_w;
      logic [2:0] pad_h;
      logic [2:0] pad_w;
   } cfg_type;

   // one classified command: opcode, empty flag, position, channel, sample, window origin and extents
   typedef struct packed {
      logic        query;
      logic        empty;
      logic [5:0]  row;
      logic [5:0]  col;
      logic [3:0]  channel;
      logic [31:0] sample;
      logic [15:0] y0;
      logic [15:0] x0;
      logic [4:0]  kh;
      logic [4:0]  kw;
   } cmd_type;

   function automatic logic greater_bits(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ka;
      logic [31:0] kb;
      logic        nan_a;
      logic        nan_b;
      nan_a = a[30:0] > 31'h7F80_0000;
      nan_b = b[30:0] > 31'h7F80_0000;
      ka = (a[30:0] == 31'd0) ? 32'h8000_0000 : (a[31] ? ~a : (a | 32'h8000_0000));
      kb = (b[30:0] == 31'd0) ? 32'h8000_0000 : (b[31] ? ~b : (b | 32'h8000_0000));
      return !nan_a && !nan_b && (ka > kb);
   endfunction

endpackage

// ----- design/mpw_ram.sv -----
// ----------------------------------------------------------------------------
// mpw_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mpw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ----- design/mpw_front.sv -----
// ----------------------------------------------------------------------------
// mpw_front
// Accepts words, computes window origin and extents, fills a short queue.
// ----------------------------------------------------------------------------
module mpw_front #(
   parameter int MAX_HEIGHT   = 64,
   parameter int MAX_WIDTH    = 64,
   parameter int MAX_CHANNELS = 16,
   parameter int MAX_KERNEL   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  mpw_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_opcode,
   input  logic [5:0]       req_row,
   input  logic [5:0]       req_col,
   input  logic [3:0]       req_channel,
   input  logic [31:0]      req_sample,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output mpw_pkg::cmd_type cmd
);
   import mpw_pkg::*;

   localparam int QD = 2;

   cmd_type       q_ff [QD];
   cmd_type       q_in;
   logic [1:0]    count_ff, count_in;
   logic          rd_ff, rd_in;
   logic          wr_ff, wr_in;
   logic          push;
   logic [10:0]   eh, ew;
   logic [4:0]    kh, kw;
   logic [10:0]   ys, xs;
   logic          chan_ok;

   assign req_stall = (count_ff == 2'(QD));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ff];

   always_comb begin
      eh = (32'(cfg.in_height) > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : 11'(cfg.in_height);
      ew = (32'(cfg.in_width) > MAX_WIDTH) ? 11'(MAX_WIDTH) : 11'(cfg.in_width);
      kh = (32'(cfg.kernel_h) > MAX_KERNEL) ? 5'(MAX_KERNEL) : 5'(cfg.kernel_h);
      kw = (32'(cfg.kernel_w) > MAX_KERNEL) ? 5'(MAX_KERNEL) : 5'(cfg.kernel_w);
      ys = 11'(req_row) * 11'(cfg.stride_h);
      xs = 11'(req_col) * 11'(cfg.stride_w);
      chan_ok = 32'(req_channel) < MAX_CHANNELS;
      q_in.query   = (req_opcode == OP_QUERY);
      q_in.row     = req_row;
      q_in.col     = req_col;
      q_in.channel = req_channel;
      q_in.sample  = req_sample;
      q_in.y0      = 16'(ys) - 16'(cfg.pad_h);
      q_in.x0      = 16'(xs) - 16'(cfg.pad_w);
      q_in.kh      = kh;
      q_in.kw      = kw;
      q_in.empty   = (q_in.query && (!chan_ok || (eh == 11'd0) || (ew == 11'd0))) ||
                     (!q_in.query && (32'(req_row) >= MAX_HEIGHT ||
                      32'(req_col) >= MAX_WIDTH || !chan_ok));
   end

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(cmd_take);
      rd_in    = rd_ff ^ cmd_take;
      wr_in    = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
      if (push) begin
         q_ff[wr_ff] <= q_in;
      end
   end
endmodule

// ----- design/mpw_back.sv -----
// ----------------------------------------------------------------------------
// mpw_back
// Executes stores and walks query windows one tap per cycle.
// ----------------------------------------------------------------------------
module mpw_back #(
   parameter int MAX_HEIGHT   = 64,
   parameter int MAX_WIDTH    = 64,
   parameter int MAX_CHANNELS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  mpw_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  mpw_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [31:0]      rsp_max_value
);
   import mpw_pkg::*;

   localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_WALK = 4'b0010,
      S_LAST = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   cmd_type      cur_ff, cur_in;
   logic [4:0]   dy_ff, dy_in, dx_ff, dx_in;
   logic [31:0]  best_ff, best_in;
   logic         rv_ff, rv_in;
   logic         vld_ff, vld_in;
   logic [31:0]  out_ff, out_in;
   logic         ram_we;
   logic [AW-1:0] ram_addr;
   logic [31:0]  ram_q;
   logic signed [16:0] y, x;
   logic         tap_ok;
   logic         last_tap;
   logic [10:0]  eh, ew;

   assign rsp_valid     = vld_ff;
   assign rsp_max_value = out_ff;

   always_comb begin
      eh = (32'(cfg.in_height) > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : 11'(cfg.in_height);
      ew = (32'(cfg.in_width) > MAX_WIDTH) ? 11'(MAX_WIDTH) : 11'(cfg.in_width);
      y  = $signed({cur_ff.y0[15], cur_ff.y0}) + 17'(dy_ff);
      x  = $signed({cur_ff.x0[15], cur_ff.x0}) + 17'(dx_ff);
      tap_ok = (y >= 0) && (x >= 0) && (y < $signed(17'(eh))) && (x < $signed(17'(ew)));
      last_tap = (dx_ff + 5'd1 >= cur_ff.kw) && (dy_ff + 5'd1 >= cur_ff.kh);
   end

   always_comb begin
      ram_we   = 1'b0;
      ram_addr = AW'((32'(y[15:0]) * MAX_WIDTH + 32'(x[15:0])) * MAX_CHANNELS +
                     32'(cur_ff.channel));
      if (state_ff == S_IDLE && cmd_valid && !cmd.query) begin
         ram_we   = !cmd.empty;
         ram_addr = AW'((32'(cmd.row) * MAX_WIDTH + 32'(cmd.col)) * MAX_CHANNELS +
                        32'(cmd.channel));
      end
   end

   mpw_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (cmd.sample),
      .rd_data (ram_q)
   );

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      dy_in    = dy_ff;
      dx_in    = dx_ff;
      best_in  = best_ff;
      rv_in    = 1'b0;
      vld_in   = vld_ff && rsp_stall;
      out_in   = out_ff;
      cmd_take = 1'b0;
      if (rv_ff && greater_bits(ram_q, best_ff)) begin
         best_in = ram_q;
      end
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               if (cmd.query) begin
                  cur_in  = cmd;
                  dy_in   = '0;
                  dx_in   = '0;
                  best_in = NEG_FLT_MAX;
                  if (cmd.empty || cmd.kh == 5'd0 || cmd.kw == 5'd0) begin
                     state_in = S_LAST;
                  end else begin
                     state_in = S_WALK;
                  end
               end
            end
         end
         S_WALK: begin
            rv_in = tap_ok;
            if (last_tap) begin
               state_in = S_LAST;
            end else if (dx_ff + 5'd1 >= cur_ff.kw) begin
               dx_in = '0;
               dy_in = dy_ff + 5'd1;
            end else begin
               dx_in = dx_ff + 5'd1;
            end
         end
         S_LAST: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!vld_ff || !rsp_stall) begin
               vld_in   = 1'b1;
               out_in   = best_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         vld_ff   <= vld_in;
      end
      cur_ff  <= cur_in;
      dy_ff   <= dy_in;
      dx_ff   <= dx_in;
      best_ff <= best_in;
      out_ff  <= out_in;
   end
endmodule

// ----- design/max_pool_window_engine_top.sv -----
// ----------------------------------------------------------------------------
// max_pool_window_engine_top
// A store word is executed as soon as the execution unit takes it; a query
// walks kernel_h*kernel_w window taps (with both kernel sizes saturated to
// MAX_KERNEL): a dispatch step, one window tap per cycle of the single-port
// sample memory, a read latency step and a result hand-off step. A query
// with an empty window (zero size or bad channel) skips the tap walk.
// A two-entry command queue lets new words arrive while a window is walked.
// ----------------------------------------------------------------------------
module max_pool_window_engine_top #(
   parameter int MAX_HEIGHT   = 64,
   parameter int MAX_WIDTH    = 64,
   parameter int MAX_CHANNELS = 16,
   parameter int MAX_KERNEL   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [5:0]  req_row,
   input  logic [5:0]  req_col,
   input  logic [3:0]  req_channel,
   input  logic [31:0] req_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_max_value,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mpw_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   logic       cmd_valid;
   logic       cmd_take;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (32'(idx))
            CSR_IN_HEIGHT: cfg_in.in_height = csr_pwdata[6:0];
            CSR_IN_WIDTH:  cfg_in.in_width  = csr_pwdata[6:0];
            CSR_KERNEL_H:  cfg_in.kernel_h  = csr_pwdata[3:0];
            CSR_KERNEL_W:  cfg_in.kernel_w  = csr_pwdata[3:0];
            CSR_STRIDE_H:  cfg_in.stride_h  = csr_pwdata[3:0];
            CSR_STRIDE_W:  cfg_in.stride_w  = csr_pwdata[3:0];
            CSR_PAD_H:     cfg_in.pad_h     = csr_pwdata[2:0];
            CSR_PAD_W:     cfg_in.pad_w     = csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (32'(idx))
         CSR_IN_HEIGHT: csr_prdata = 32'(cfg_ff.in_height);
         CSR_IN_WIDTH:  csr_prdata = 32'(cfg_ff.in_width);
         CSR_KERNEL_H:  csr_prdata = 32'(cfg_ff.kernel_h);
         CSR_KERNEL_W:  csr_prdata = 32'(cfg_ff.kernel_w);
         CSR_STRIDE_H:  csr_prdata = 32'(cfg_ff.stride_h);
         CSR_STRIDE_W:  csr_prdata = 32'(cfg_ff.stride_w);
         CSR_PAD_H:     csr_prdata = 32'(cfg_ff.pad_h);
         CSR_PAD_W:     csr_prdata = 32'(cfg_ff.pad_w);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{in_height: 7'd64, in_width: 7'd64, kernel_h: 4'd2, kernel_w: 4'd2,
                     stride_h: 4'd2, stride_w: 4'd2, pad_h: 3'd0, pad_w: 3'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mpw_front #(
      .MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH),
      .MAX_CHANNELS(MAX_CHANNELS), .MAX_KERNEL(MAX_KERNEL)
   ) u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_row(req_row), .req_col(req_col), .req_channel(req_channel),
      .req_sample(req_sample),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
   );

   mpw_back #(
      .MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS)
   ) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_max_value(rsp_max_value)
   );
endmodule

// ----- bench/tb_max_pool_window_engine_top.sv -----
// ----------------------------------------------------------------------------
// tb_max_pool_window_engine_top
// Stores samples into the image memory and queries pooled elements under a
// series of window settings, from reset values through zero and saturating
// extremes. Every result is compared with a window maximum predicted inside
// the bench. Queries first load any in-image tap not yet written.
// ----------------------------------------------------------------------------
module tb_max_pool_window_engine_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mpw_pkg::*;

   localparam int MEM_WORDS = 64 * 64 * 16;
   localparam int WDOG_LIMIT = 20000;

   class pool_scoreboard;
      logic [31:0] image_mem [MEM_WORDS];
      bit   [31:0] regs [8];
      logic [31:0] expected_max [$];
      int          errors;

      function new();
         regs = '{64, 64, 2, 2, 2, 2, 0, 0};
         errors = 0;
      endfunction

      function void write_reg(int idx, bit [31:0] v);
         case (idx)
            CSR_IN_HEIGHT, CSR_IN_WIDTH: regs[idx] = v & 32'h7F;
            CSR_PAD_H, CSR_PAD_W:        regs[idx] = v & 32'h7;
            default:                     regs[idx] = v & 32'hF;
         endcase
      endfunction

      function int clamped(int idx, int hi);
         return (regs[idx] > hi) ? hi : int'(regs[idx]);
      endfunction

      function void window_taps(int row, int col, int ch, ref int taps[$]);
         int eh, ew, kh, kw, y0, x0, y, x;
         taps.delete();
         eh = clamped(CSR_IN_HEIGHT, 64);
         ew = clamped(CSR_IN_WIDTH, 64);
         kh = clamped(CSR_KERNEL_H, 8);
         kw = clamped(CSR_KERNEL_W, 8);
         y0 = row * int'(regs[CSR_STRIDE_H]) - int'(regs[CSR_PAD_H]);
         x0 = col * int'(regs[CSR_STRIDE_W]) - int'(regs[CSR_PAD_W]);
         for (int dy = 0; dy < kh; dy++) begin
            y = y0 + dy;
            if (y >= 0 && y < eh)
               for (int dx = 0; dx < kw; dx++) begin
                  x = x0 + dx;
                  if (x >= 0 && x < ew)
                     taps.push_back((y * 64 + x) * 16 + ch);
               end
         end
      endfunction

      function bit is_nan(logic [31:0] b);
         return b[30:0] > 31'h7F80_0000;
      endfunction

      function logic [31:0] order_of(logic [31:0] b);
         if (b[30:0] == 31'd0)
            return 32'h8000_0000;
         return b[31] ? ~b : {1'b1, b[30:0]};
      endfunction

      function void note_word(logic op, int row, int col, int ch, logic [31:0] sample);
         int taps[$];
         logic [31:0] best;
         if (op == OP_STORE) begin
            image_mem[(row * 64 + col) * 16 + ch] = sample;
            return;
         end
         best = NEG_FLT_MAX;
         window_taps(row, col, ch, taps);
         foreach (taps[i])
            if (!is_nan(image_mem[taps[i]]) && !is_nan(best) &&
                order_of(image_mem[taps[i]]) > order_of(best))
               best = image_mem[taps[i]];
         expected_max.push_back(best);
      endfunction

      function void check_result(logic [31:0] got);
         logic [31:0] want;
         if (expected_max.size() == 0) begin
            $display("%0t: unexpected word max_value=%08h", $time, got);
            errors++;
            return;
         end
         want = expected_max.pop_front();
         if (got !== want) begin
            $display("%0t: max_value expected %08h actual %08h", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_opcode;
   logic [5:0]  req_row;
   logic [5:0]  req_col;
   logic [3:0]  req_channel;
   logic [31:0] req_sample;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_max_value;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pool_scoreboard sb = new();
   bit  written [MEM_WORDS];
   int  send_idle_pct;
   int  recv_stall_pct;
   int  hold_left;
   int  progress;
   int  item_count;

   max_pool_window_engine_top DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: stall pattern, hold-off and result check
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_max_value);
         progress++;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   int idle_cycles;
   int last_progress;
   always @(posedge clock) begin
      if (progress != last_progress || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      last_progress = progress;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("tb_max_pool_window_engine_top: errors");
         $finish;
      end
   end

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
         3: return 32'h7F80_0000;
         4: return 32'hFF80_0000;
         5: return NEG_FLT_MAX;
         6: return 32'h7F7F_FFFF;
         7: return $urandom_range(1) ? 32'h3F80_0000 : 32'hBF80_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic put_word(logic op, int row, int col, int ch, logic [31:0] sample);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_row     <= row[5:0];
      req_col     <= col[5:0];
      req_channel <= ch[3:0];
      req_sample  <= sample;
      do @(posedge clock); while (req_stall);
      progress++;
      item_count++;
      sb.note_word(op, row, col, ch, sample);
      if (op == OP_STORE)
         written[(row * 64 + col) * 16 + ch] = 1'b1;
   endtask

   task automatic store(int row, int col, int ch, logic [31:0] sample);
      put_word(OP_STORE, row, col, ch, sample);
   endtask

   task automatic query(int row, int col, int ch);
      int taps[$];
      sb.window_taps(row, col, ch, taps);
      foreach (taps[i])
         if (!written[taps[i]])
            store(taps[i] / 1024, (taps[i] / 16) % 64, taps[i] % 16, rand_sample());
      put_word(OP_QUERY, row, col, ch, $urandom);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_max.size() != 0)
         @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic write_csr(int idx, bit [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 5'(4 * idx);
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.write_reg(idx, v);
      progress++;
   endtask

   task automatic set_window(int h, int w, int kh, int kw, int sh, int sw, int ph, int pw);
      write_csr(CSR_IN_HEIGHT, h);
      write_csr(CSR_IN_WIDTH, w);
      write_csr(CSR_KERNEL_H, kh);
      write_csr(CSR_KERNEL_W, kw);
      write_csr(CSR_STRIDE_H, sh);
      write_csr(CSR_STRIDE_W, sw);
      write_csr(CSR_PAD_H, ph);
      write_csr(CSR_PAD_W, pw);
   endtask

   function automatic int span(int size_idx, int stride_idx, int pad_idx);
      int lim;
      if (sb.regs[stride_idx] == 0 || $urandom_range(9) == 0)
         return 63;
      lim = (sb.clamped(size_idx, 64) + int'(sb.regs[pad_idx])) /
            int'(sb.regs[stride_idx]) + 1;
      return (lim > 63) ? 63 : lim;
   endfunction

   task automatic random_words(int n);
      int stop_at;
      stop_at = item_count + n;
      while (item_count < stop_at) begin
         if ($urandom_range(99) < 20)
            store($urandom_range(63), $urandom_range(63), $urandom_range(15), rand_sample());
         else
            query($urandom_range(span(CSR_IN_HEIGHT, CSR_STRIDE_H, CSR_PAD_H)),
                  $urandom_range(span(CSR_IN_WIDTH, CSR_STRIDE_W, CSR_PAD_W)),
                  $urandom_range(15));
      end
   endtask

   task automatic set_idling(int phase);
      case (phase % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
         default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_opcode  <= OP_STORE;
      req_row     <= '0;
      req_col     <= '0;
      req_channel <= '0;
      req_sample  <= '0;
      rsp_stall   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 0;
      progress = 0;
      item_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset window: NaN, signed zeros, -FLT_MAX, infinities, corners
      store(0, 0, 0, 32'hFFFF_FFFF);
      store(0, 1, 0, 32'h8000_0000);
      store(1, 0, 0, 32'h0000_0000);
      store(1, 1, 0, NEG_FLT_MAX);
      query(0, 0, 0);
      store(62, 62, 15, 32'hFF80_0000);
      store(62, 63, 15, 32'h7FC0_0000);
      store(63, 62, 15, 32'h7F80_0000);
      store(63, 63, 15, 32'h7F7F_FFFF);
      query(31, 31, 15);
      query(40, 0, 15);
      query(0, 63, 7);
      query(63, 63, 0);
      random_words(60);
      drain();

      for (int phase = 1; phase <= 13; phase++) begin
         case (phase)
            1:  set_window(8, 8, 3, 3, 1, 1, 1, 1);
            2:  set_window(127, 127, 15, 15, 15, 15, 7, 7);
            3:  set_window(0, 5, 2, 2, 1, 1, 0, 0);
            4:  set_window(6, 6, 0, 3, 1, 1, 0, 0);
            5:  set_window(10, 10, 3, 3, 0, 0, 2, 2);
            6:  set_window(1, 1, 1, 1, 1, 1, 0, 0);
            7:  set_window(64, 64, 8, 8, 8, 8, 7, 7);
            8:  set_window(12, 9, 3, 2, 2, 3, 1, 0);
            default:
               set_window($urandom_range(1, 16), $urandom_range(1, 16),
                          $urandom_range(15), $urandom_range(15),
                          $urandom_range(15), $urandom_range(15),
                          $urandom_range(7), $urandom_range(7));
         endcase
         set_idling(phase);
         if (phase == 4)
            hold_left = 1500;
         random_words(75);
         drain();
      end

      if (sb.errors == 0)
         $display("tb_max_pool_window_engine_top: clean");
      else
         $display("tb_max_pool_window_engine_top: errors");
      $finish;
   end

endmodule
